[src/nptc_pkg.sv]
// Shared types and constants of the near plane triangle clipper.
`timescale 1ns / 1ps
`default_nettype none
package nptc_pkg;

    localparam int WORD_W     = 32;
    localparam int VTX_WORDS  = 6;
    localparam int ATTR_COUNT = 2;
    localparam int DIV_W      = 50;   // dividend / quotient magnitude bits
    localparam int DVS_W      = 34;   // divisor magnitude bits
    localparam int DCNT_W     = $clog2(DIV_W + 1);
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y = 3'd3;

    localparam logic [2:0] W_X = 3'd0;
    localparam logic [2:0] W_Y = 3'd1;
    localparam logic [2:0] W_Z = 3'd2;
    localparam logic [2:0] W_W = 3'd3;
    localparam logic [2:0] W_S = 3'd4;
    localparam logic [2:0] W_T = 3'd5;

    typedef logic [VTX_WORDS-1:0][WORD_W-1:0] t_words;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] pos_w;
        logic signed [31:0] attr_s;
        logic signed [31:0] attr_t;
    } t_vtx_in;

    typedef struct packed {
        logic signed [31:0] scr_x;
        logic signed [31:0] scr_y;
        logic signed [31:0] scr_z;
        logic signed [31:0] out_s;
        logic signed [31:0] out_t;
        logic               tri_end;
        logic               run_end;
    } t_vtx_out;

    // vertex source for an emitted vertex
    typedef enum logic [2:0] {
        SRC_V0 = 3'd0,
        SRC_V1 = 3'd1,
        SRC_V2 = 3'd2,
        SRC_IA = 3'd3,
        SRC_IB = 3'd4
    } t_src;

    typedef struct packed {
        logic       load_vtx;
        logic [1:0] slot;
        logic       div_start;
        logic       div_t;      // divider operands: edge parameter, else w divide
        logic [1:0] c_idx;
        logic [1:0] k_idx;
        logic       t_cap;
        logic       mul_en;
        logic       mul_vp;     // viewport multiply, else lerp multiply
        logic       mul_y;
        logic       lerp_wr;
        logic       dst_b;
        logic [2:0] word;
        t_src       src;
        logic       q_cap;
        logic       vp_wr_x;
        logic       vp_wr_y;
        logic       out_load;
        logic       tri_end;
        logic       run_end;
    } t_cmd;

    typedef struct packed {
        logic [2:0] clip;
        logic       div_done;
    } t_sts;

endpackage
`default_nettype wire

[src/nptc_div.sv]
// Radix-2 restoring signed divider, truncating quotient, one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module nptc_div import nptc_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic signed [DIV_W-1:0] i_num,
    input  wire logic signed [DVS_W-1:0] i_den,
    output logic                         o_done,
    output logic signed [DIV_W-1:0]      o_quo
);
    logic              r_busy, r_done, r_neg;
    logic [DCNT_W-1:0] r_cnt;
    logic [DVS_W-1:0]  r_rem, r_d;
    logic [DIV_W-1:0]  r_quo;
    logic [DVS_W:0]    trial, diff;
    logic              ge;

    assign trial = {r_rem, r_quo[DIV_W-1]};
    assign ge    = trial >= {1'b0, r_d};
    assign diff  = trial - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DCNT_W'(DIV_W);
                r_rem  <= '0;
                r_quo  <= i_num[DIV_W-1] ? $unsigned(-i_num) : $unsigned(i_num);
                r_d    <= i_den[DVS_W-1] ? $unsigned(-i_den) : $unsigned(i_den);
                r_neg  <= i_num[DIV_W-1] ^ i_den[DVS_W-1];
            end else if (r_busy) begin
                r_rem <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
                r_quo <= {r_quo[DIV_W-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_neg ? -$signed(r_quo) : $signed(r_quo);
endmodule
`default_nettype wire

[src/nptc_datapath.sv]
// Datapath: vertex store, edge intersection, w divide, viewport map, output register.
`timescale 1ns / 1ps
`default_nettype none
module nptc_datapath import nptc_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [31:0]          i_cfg_data,
    input  wire t_vtx_in              i_in_data,
    input  wire t_cmd                 i_cmd,
    output t_sts                      o_sts,
    output t_vtx_out                  o_out_data
);
    t_words             r_vtx [3];
    t_words             r_ia, r_ib;
    logic [31:0]        r_scale_x, r_offset_x, r_scale_y, r_offset_y;
    logic [16:0]        r_t;
    logic signed [65:0] r_prod;
    logic [31:0]        r_q [3];
    logic [31:0]        r_ex, r_ey;
    t_vtx_out           r_out;

    t_words             c_w, k_w, s_w;
    logic signed [32:0] num;
    logic signed [33:0] den;
    logic signed [DIV_W-1:0] div_n, quo;
    logic signed [DVS_W-1:0] div_d;
    logic               div_done;
    logic signed [32:0] mul_a, mul_b;
    logic signed [31:0] s_cur, w_cur;

    function automatic logic [31:0] sat32(input logic signed [50:0] a);
        if (a > 51'sd2147483647)       return 32'h7fff_ffff;
        else if (a < -51'sd2147483648) return 32'h8000_0000;
        else                           return a[31:0];
    endfunction

    function automatic t_words pick(input logic [1:0] idx, input t_words v0,
                                    input t_words v1, input t_words v2);
        case (idx)
            2'd0:    return v0;
            2'd1:    return v1;
            default: return v2;
        endcase
    endfunction

    always_comb begin
        c_w = pick(i_cmd.c_idx, r_vtx[0], r_vtx[1], r_vtx[2]);
        k_w = pick(i_cmd.k_idx, r_vtx[0], r_vtx[1], r_vtx[2]);
        case (i_cmd.src)
            SRC_V0:  s_w = r_vtx[0];
            SRC_V1:  s_w = r_vtx[1];
            SRC_V2:  s_w = r_vtx[2];
            SRC_IA:  s_w = r_ia;
            default: s_w = r_ib;
        endcase
    end

    assign s_cur = $signed(s_w[i_cmd.word]);
    assign w_cur = $signed(s_w[W_W]);

    // edge parameter operands
    assign num = {c_w[W_Z][31], c_w[W_Z]} - {c_w[W_W][31], c_w[W_W]};
    assign den = {num[32], num} + {{2{k_w[W_W][31]}}, k_w[W_W]}
               - {{2{k_w[W_Z][31]}}, k_w[W_Z]};

    always_comb begin
        if (i_cmd.div_t) begin
            div_n = {num[32], num, 16'd0};
            div_d = den;
        end else begin
            div_n = {{2{s_cur[31]}}, s_cur, 16'd0};
            div_d = {{2{w_cur[31]}}, w_cur};
        end
    end

    nptc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_n),
        .i_den   (div_d),
        .o_done  (div_done),
        .o_quo   (quo)
    );

    always_comb begin
        if (i_cmd.mul_vp) begin
            mul_a = i_cmd.mul_y ? {r_q[1][31], r_q[1]} : {r_q[0][31], r_q[0]};
            mul_b = i_cmd.mul_y ? {r_scale_y[31], r_scale_y} : {r_scale_x[31], r_scale_x};
        end else begin
            mul_a = {k_w[i_cmd.word][31], k_w[i_cmd.word]}
                  - {c_w[i_cmd.word][31], c_w[i_cmd.word]};
            mul_b = {16'd0, r_t};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_x  <= 32'h0001_0000;
            r_offset_x <= '0;
            r_scale_y  <= 32'h0001_0000;
            r_offset_y <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SCALE_X:  r_scale_x  <= i_cfg_data;
                CFG_OFFSET_X: r_offset_x <= i_cfg_data;
                CFG_SCALE_Y:  r_scale_y  <= i_cfg_data;
                CFG_OFFSET_Y: r_offset_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_vtx) begin
            r_vtx[i_cmd.slot] <= {i_in_data.attr_t, i_in_data.attr_s, i_in_data.pos_w,
                                  i_in_data.pos_z, i_in_data.pos_y, i_in_data.pos_x};
        end
        if (i_cmd.t_cap) begin
            if (den == '0 || quo < 0)                  r_t <= '0;
            else if (quo > $signed(DIV_W'(65536)))     r_t <= 17'h10000;
            else                                       r_t <= quo[16:0];
        end
        if (i_cmd.mul_en) r_prod <= mul_a * mul_b;
        if (i_cmd.lerp_wr) begin
            if (i_cmd.dst_b)
                r_ib[i_cmd.word] <= sat32({{19{c_w[i_cmd.word][31]}}, c_w[i_cmd.word]}
                                          + {r_prod[65], r_prod[65:16]});
            else
                r_ia[i_cmd.word] <= sat32({{19{c_w[i_cmd.word][31]}}, c_w[i_cmd.word]}
                                          + {r_prod[65], r_prod[65:16]});
        end
        if (i_cmd.q_cap) begin
            if (w_cur == 0)
                r_q[i_cmd.word[1:0]] <= (s_cur > 0) ? 32'h7fff_ffff :
                                        (s_cur < 0) ? 32'h8000_0000 : 32'h0;
            else
                r_q[i_cmd.word[1:0]] <= sat32({quo[DIV_W-1], quo});
        end
        if (i_cmd.vp_wr_x)
            r_ex <= sat32({r_prod[65], r_prod[65:16]} + {{19{r_offset_x[31]}}, r_offset_x});
        if (i_cmd.vp_wr_y)
            r_ey <= sat32({r_prod[65], r_prod[65:16]} + {{19{r_offset_y[31]}}, r_offset_y});
        if (i_cmd.out_load) begin
            r_out.scr_x   <= r_ex;
            r_out.scr_y   <= r_ey;
            r_out.scr_z   <= r_q[2];
            r_out.out_s   <= (ATTR_COUNT > 0) ? s_w[W_S] : '0;
            r_out.out_t   <= (ATTR_COUNT > 1) ? s_w[W_T] : '0;
            r_out.tri_end <= i_cmd.tri_end;
            r_out.run_end <= i_cmd.run_end;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_sts.clip[i] = $signed(r_vtx[i][W_W]) < 0 ||
                            $signed(r_vtx[i][W_Z]) > $signed(r_vtx[i][W_W]);
        end
        o_sts.div_done = div_done;
    end

    assign o_out_data = r_out;
endmodule
`default_nettype wire

[src/nptc_ctrl.sv]
// Controller: vertex count, clip case decode and step sequencing.
`timescale 1ns / 1ps
`default_nettype none
module nptc_ctrl import nptc_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);
    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_CLASS  = 13'b0000000000010,
        S_TSTART = 13'b0000000000100,
        S_TWAIT  = 13'b0000000001000,
        S_LMUL   = 13'b0000000010000,
        S_LADD   = 13'b0000000100000,
        S_QSTART = 13'b0000001000000,
        S_QWAIT  = 13'b0000010000000,
        S_VMX    = 13'b0000100000000,
        S_VAX    = 13'b0001000000000,
        S_VMY    = 13'b0010000000000,
        S_VAY    = 13'b0100000000000,
        S_OUT    = 13'b1000000000000
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_cnt, n_cnt;
    t_src       r_list [6];
    t_src       n_list [6];
    logic [2:0] r_n, n_n, r_e, n_e, r_word, n_word;
    logic       r_pass, n_pass, r_out_valid, n_out_valid;
    logic [1:0] r_ca, r_ka, r_cb, r_kb, n_ca, n_ka, n_cb, n_kb;
    logic [1:0] nc, sel, nxt, prv;
    logic       out_free;

    function automatic t_src to_src(input logic [1:0] i);
        case (i)
            2'd0:    return SRC_V0;
            2'd1:    return SRC_V1;
            default: return SRC_V2;
        endcase
    endfunction

    assign nc  = {1'b0, i_sts.clip[0]} + {1'b0, i_sts.clip[1]} + {1'b0, i_sts.clip[2]};
    // clipped vertex for one clip, kept vertex for two
    always_comb begin
        if (nc == 2'd1) sel = i_sts.clip[0] ? 2'd0 : (i_sts.clip[1] ? 2'd1 : 2'd2);
        else            sel = !i_sts.clip[0] ? 2'd0 : (!i_sts.clip[1] ? 2'd1 : 2'd2);
    end
    assign nxt = (sel == 2'd2) ? 2'd0 : sel + 2'd1;
    assign prv = (sel == 2'd0) ? 2'd2 : sel - 2'd1;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_list      = r_list;
        n_n         = r_n;
        n_e         = r_e;
        n_word      = r_word;
        n_pass      = r_pass;
        n_ca        = r_ca;
        n_ka        = r_ka;
        n_cb        = r_cb;
        n_kb        = r_kb;
        n_out_valid = r_out_valid && !i_out_ready;
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        o_cmd.slot  = r_cnt;
        o_cmd.c_idx = r_pass ? r_cb : r_ca;
        o_cmd.k_idx = r_pass ? r_kb : r_ka;
        o_cmd.word  = r_word;
        o_cmd.src   = r_list[r_e];
        o_cmd.dst_b = r_pass;
        o_cmd.div_t = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.load_vtx = i_in_valid;
                if (i_in_valid) begin
                    if (r_cnt == 2'd2) begin
                        n_cnt   = 2'd0;
                        n_state = S_CLASS;
                    end else begin
                        n_cnt = r_cnt + 2'd1;
                    end
                end
            end
            S_CLASS: begin
                n_e    = '0;
                n_word = '0;
                n_pass = 1'b0;
                if (i_sts.clip == 3'b111) begin
                    n_state = S_IDLE;
                end else if (i_sts.clip == 3'b000) begin
                    n_list[0] = SRC_V0;
                    n_list[1] = SRC_V1;
                    n_list[2] = SRC_V2;
                    n_n       = 3'd3;
                    n_state   = S_QSTART;
                end else if (nc == 2'd1) begin
                    n_list[0] = SRC_IA;
                    n_list[1] = to_src(nxt);
                    n_list[2] = to_src(prv);
                    n_list[3] = SRC_IA;
                    n_list[4] = to_src(prv);
                    n_list[5] = SRC_IB;
                    n_n       = 3'd6;
                    n_ca      = sel;
                    n_ka      = nxt;
                    n_cb      = sel;
                    n_kb      = prv;
                    n_state   = S_TSTART;
                end else begin
                    n_list[0] = to_src(sel);
                    n_list[1] = SRC_IA;
                    n_list[2] = SRC_IB;
                    n_n       = 3'd3;
                    n_ca      = nxt;
                    n_ka      = sel;
                    n_cb      = prv;
                    n_kb      = sel;
                    n_state   = S_TSTART;
                end
            end
            S_TSTART: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_TWAIT;
            end
            S_TWAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.t_cap = 1'b1;
                    n_word      = '0;
                    n_state     = S_LMUL;
                end
            end
            S_LMUL: begin
                o_cmd.mul_en = 1'b1;
                n_state      = S_LADD;
            end
            S_LADD: begin
                o_cmd.lerp_wr = 1'b1;
                if (r_word == W_T) begin
                    n_word = '0;
                    if (!r_pass) begin
                        n_pass  = 1'b1;
                        n_state = S_TSTART;
                    end else begin
                        n_e     = '0;
                        n_state = S_QSTART;
                    end
                end else begin
                    n_word  = r_word + 3'd1;
                    n_state = S_LMUL;
                end
            end
            S_QSTART: begin
                o_cmd.div_t     = 1'b0;
                o_cmd.div_start = 1'b1;
                n_state         = S_QWAIT;
            end
            S_QWAIT: begin
                o_cmd.div_t = 1'b0;
                if (i_sts.div_done) begin
                    o_cmd.q_cap = 1'b1;
                    if (r_word == W_Z) begin
                        n_state = S_VMX;
                    end else begin
                        n_word  = r_word + 3'd1;
                        n_state = S_QSTART;
                    end
                end
            end
            S_VMX: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_vp = 1'b1;
                n_state      = S_VAX;
            end
            S_VAX: begin
                o_cmd.vp_wr_x = 1'b1;
                n_state       = S_VMY;
            end
            S_VMY: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_vp = 1'b1;
                o_cmd.mul_y  = 1'b1;
                n_state      = S_VAY;
            end
            S_VAY: begin
                o_cmd.vp_wr_y = 1'b1;
                n_state       = S_OUT;
            end
            S_OUT: begin
                o_cmd.tri_end = (r_e == 3'd2) || (r_e == 3'd5);
                o_cmd.run_end = (r_e == r_n - 3'd1);
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_word         = '0;
                    if (r_e == r_n - 3'd1) begin
                        n_state = S_IDLE;
                    end else begin
                        n_e     = r_e + 3'd1;
                        n_state = S_QSTART;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_e         <= '0;
            r_n         <= '0;
            r_word      <= '0;
            r_pass      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            r_e         <= n_e;
            r_n         <= n_n;
            r_word      <= n_word;
            r_pass      <= n_pass;
        end
    end

    always_ff @(posedge i_clk) begin
        r_list <= n_list;
        r_ca   <= n_ca;
        r_ka   <= n_ka;
        r_cb   <= n_cb;
        r_kb   <= n_kb;
    end

    assign o_out_valid = r_out_valid;

`ifndef ASSERT_OFF
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("output beat overwritten");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("vertex count out of range");
    a_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.div_done |-> (r_state == S_TWAIT || r_state == S_QWAIT))
        else $error("divider finished outside a wait step");
    a_emit_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT |-> (r_e < r_n))
        else $error("emit index past vertex count");
`endif
endmodule
`default_nettype wire

[src/near_plane_triangle_clipper_core.sv]
// Top level of the near plane triangle clipper: controller plus datapath.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+--------------------------
//  in       | i_in_valid / o_in_ready      | i_in_data  (t_vtx_in)
//  out      | o_out_valid / i_out_ready    | o_out_data (t_vtx_out)
//  cfg      | i_cfg_we (no wait)           | i_cfg_idx, i_cfg_data
//
// First two vertex beats of a triangle are stored.
// The third starts the run: per intersection an edge parameter divide, then a
// multiply and add per vertex word; per emitted vertex three divides by w, then the
// viewport multiply and add for x and y, and the output step; the single shared
// bit-serial divider sets the rate.
// A stall on the output holds the sequencer in its output step only.
// Reset (i_rst_n low, synchronous) clears the count and sets the viewport registers to scale 1.0, offset 0 (Q16.16).
`timescale 1ns / 1ps
`default_nettype none
module near_plane_triangle_clipper_core import nptc_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire t_vtx_in              i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output t_vtx_out                  o_out_data,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [31:0]          i_cfg_data
);
    t_cmd cmd;
    t_sts sts;

    // sequencer: counts vertex beats, decodes the clip case, steps the units
    nptc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // datapath: vertex registers, divider, shared multiplier, output register
    nptc_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out_data (o_out_data)
    );
endmodule
`default_nettype wire

[dv/tb_near_plane_triangle_clipper_core.sv]
// Testbench for the near plane triangle clipper: random and directed vertex beats.
`timescale 1ns / 1ps
`default_nettype none
module tb_near_plane_triangle_clipper_core;
    import nptc_pkg::*;

    typedef longint t_lv [6];

    // codes for the word slots of a vertex
    localparam int PX = 0, PY = 1, PZ = 2, PW = 3, PS = 4, PT = 5;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_BAD = 3'd4;
    localparam int DRAIN_CYCLES = 2500;  // a full six-vertex run plus margin

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 in_valid;
    logic                 o_in_ready;
    t_vtx_in              in_data;
    logic                 o_out_valid;
    logic                 out_ready;
    t_vtx_out             o_out_data;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [31:0]          cfg_data;

    near_plane_triangle_clipper_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out_data (o_out_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Pending vertex beats, and screen vertices still owed by the block.
    t_vtx_in  vtx_q [$];
    t_vtx_out scr_q [$];
    int       errors   = 0;
    int       snd_idle = 0;
    int       rcv_idle = 0;
    logic     in_beat  = 1'b0;

    // Shadow of the viewport registers and of the triangle assembly state.
    longint   vp_scale_x = 65536, vp_off_x = 0, vp_scale_y = 65536, vp_off_y = 0;
    t_lv      held [2];
    int       held_cnt = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------------
    // Predictor: clip against the near plane, divide by w, apply viewport.
    // ---------------------------------------------------------------------
    function automatic longint sat32(longint a);
        if (a > 64'sd2147483647) return 64'sd2147483647;
        if (a < -64'sd2147483648) return -64'sd2147483648;
        return a;
    endfunction

    function automatic bit behind_near(t_lv p);
        return p[PW] < 0 || p[PZ] > p[PW];
    endfunction

    // Point on the edge from the clipped vertex c toward the kept vertex k.
    function automatic t_lv edge_point(t_lv c, t_lv k);
        t_lv    r;
        longint num, den, t;
        num = c[PZ] - c[PW];
        den = num + k[PW] - k[PZ];
        t   = 0;
        if (den != 0) t = (num * 65536) / den;
        if (t < 0) t = 0;
        if (t > 65536) t = 65536;
        for (int i = 0; i < 6; i++)
            r[i] = sat32(c[i] + (((k[i] - c[i]) * t) >>> 16));
        return r;
    endfunction

    function automatic longint persp_div(longint a, longint w);
        if (w == 0) return a > 0 ? 64'sd2147483647 : (a < 0 ? -64'sd2147483648 : 0);
        return sat32((a * 65536) / w);
    endfunction

    function automatic void owe_vertex(t_lv p, bit te);
        t_vtx_out o;
        longint   nx, ny;
        nx = persp_div(p[PX], p[PW]);
        ny = persp_div(p[PY], p[PW]);
        o.scr_x   = 32'(sat32(((nx * vp_scale_x) >>> 16) + vp_off_x));
        o.scr_y   = 32'(sat32(((ny * vp_scale_y) >>> 16) + vp_off_y));
        o.scr_z   = 32'(persp_div(p[PZ], p[PW]));
        o.out_s   = ATTR_COUNT > 0 ? 32'(p[PS]) : '0;
        o.out_t   = ATTR_COUNT > 1 ? 32'(p[PT]) : '0;
        o.tri_end = te;
        o.run_end = 1'b0;
        scr_q.push_back(o);
    endfunction

    function automatic void owe_tri(t_lv a, t_lv b, t_lv c);
        owe_vertex(a, 1'b0);
        owe_vertex(b, 1'b0);
        owe_vertex(c, 1'b1);
    endfunction

    function automatic void clip_and_map(t_vtx_in d);
        t_lv v [3];
        bit  cl [3];
        int  nc, k, before_cnt;
        v[2] = '{d.pos_x, d.pos_y, d.pos_z, d.pos_w, d.attr_s, d.attr_t};
        if (held_cnt < 2) begin
            held[held_cnt] = v[2];
            held_cnt++;
            return;
        end
        held_cnt   = 0;
        v[0]       = held[0];
        v[1]       = held[1];
        nc         = 0;
        before_cnt = scr_q.size();
        for (int i = 0; i < 3; i++) begin
            cl[i] = behind_near(v[i]);
            if (cl[i]) nc++;
        end
        if (nc == 0) begin
            owe_tri(v[0], v[1], v[2]);
        end else if (nc == 1) begin
            t_lv in_n, in_p;
            k    = cl[0] ? 0 : (cl[1] ? 1 : 2);
            in_n = edge_point(v[k], v[(k + 1) % 3]);
            in_p = edge_point(v[k], v[(k + 2) % 3]);
            owe_tri(in_n, v[(k + 1) % 3], v[(k + 2) % 3]);
            owe_tri(in_n, v[(k + 2) % 3], in_p);
        end else if (nc == 2) begin
            k = !cl[0] ? 0 : (!cl[1] ? 1 : 2);
            owe_tri(v[k], edge_point(v[(k + 1) % 3], v[k]),
                    edge_point(v[(k + 2) % 3], v[k]));
        end
        if (scr_q.size() > before_cnt) scr_q[scr_q.size() - 1].run_end = 1'b1;
    endfunction

    // ---------------------------------------------------------------------
    // Driver: one beat per handshake, random gaps; ready toggled at random.
    // ---------------------------------------------------------------------
    always @(posedge i_clk) in_beat <= in_valid && o_in_ready;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_beat) begin
            if (vtx_q.size() > 0 && $urandom_range(0, 99) >= snd_idle) begin
                in_valid <= 1'b1;
                in_data  <= vtx_q.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
        out_ready <= i_rst_n && ($urandom_range(0, 99) >= rcv_idle);
    end

    // ---------------------------------------------------------------------
    // Monitor: predict on accepted input beats, check accepted output beats.
    // ---------------------------------------------------------------------
    task automatic field_check(string name, logic [31:0] exp_v, logic [31:0] got_v);
        if (exp_v !== got_v) begin
            errors++;
            $display("%0t: %s mismatch expected %h actual %h", $time, name, exp_v, got_v);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && in_valid && o_in_ready) clip_and_map(in_data);
        if (i_rst_n && o_out_valid && out_ready) begin
            if (scr_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected output beat %p", $time, o_out_data);
            end else begin
                t_vtx_out e;
                e = scr_q.pop_front();
                field_check("scr_x", e.scr_x, o_out_data.scr_x);
                field_check("scr_y", e.scr_y, o_out_data.scr_y);
                field_check("scr_z", e.scr_z, o_out_data.scr_z);
                field_check("out_s", e.out_s, o_out_data.out_s);
                field_check("out_t", e.out_t, o_out_data.out_t);
                field_check("tri_end", 32'(e.tri_end), 32'(o_out_data.tri_end));
                field_check("run_end", 32'(e.run_end), 32'(o_out_data.run_end));
            end
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------
    function automatic logic [31:0] rand_word();
        if ($urandom_range(0, 3) == 0) return $urandom;
        return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
    endfunction

    // Vertex in front of (clip = 0) or behind (clip = 1) the near plane.
    function automatic t_vtx_in rand_vtx(bit clip);
        t_vtx_in v;
        v.pos_x  = rand_word();
        v.pos_y  = rand_word();
        v.attr_s = rand_word();
        v.attr_t = rand_word();
        if (!clip) begin
            case ($urandom_range(0, 9))
                0:       v.pos_w = 0;
                1:       v.pos_w = $urandom >> 1;
                default: v.pos_w = $urandom_range(1, 32'h0040_0000);
            endcase
            v.pos_z = v.pos_w - $signed($urandom_range(0, 32'h0080_0000));
        end else if ($urandom_range(0, 1)) begin
            v.pos_w = -$signed($urandom_range(1, 32'h0040_0000));
            v.pos_z = rand_word();
        end else begin
            v.pos_w = $urandom_range(0, 32'h0040_0000);
            v.pos_z = v.pos_w + $signed($urandom_range(1, 32'h0040_0000));
        end
        return v;
    endfunction

    task automatic queue_tri(logic [2:0] clip_mask);
        for (int i = 0; i < 3; i++) vtx_q.push_back(rand_vtx(clip_mask[i]));
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = val;
        case (idx)
            CFG_SCALE_X:  vp_scale_x = longint'($signed(val));
            CFG_OFFSET_X: vp_off_x   = longint'($signed(val));
            CFG_SCALE_Y:  vp_scale_y = longint'($signed(val));
            CFG_OFFSET_Y: vp_off_y   = longint'($signed(val));
            default: ;
        endcase
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    // Wait until every beat is sent and answered, then let a silent run drain.
    task automatic wait_quiet();
        while (vtx_q.size() > 0 || in_valid || scr_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial begin
        t_vtx_in dv;
        in_valid  = 1'b0;
        in_data   = '0;
        out_ready = 1'b0;
        cfg_we    = 1'b0;
        cfg_idx   = CFG_SCALE_X;
        cfg_data  = '0;
        i_rst_n   = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Phase 0: defaults written explicitly, then directed triangles.
        snd_idle = 23;
        rcv_idle = 51;
        cfg_write(CFG_SCALE_X, 32'h0001_0000);
        cfg_write(CFG_OFFSET_X, 32'h0000_0000);
        cfg_write(CFG_SCALE_Y, 32'h0001_0000);
        cfg_write(CFG_OFFSET_Y, 32'h0000_0000);

        // nothing clipped: field extremes, and a w = 0 vertex (+x, -y, zero z)
        dv = '{32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'h7fff_ffff,
               32'h7fff_ffff, 32'h8000_0000};
        vtx_q.push_back(dv);
        dv = '{32'h0001_0000, -32'sh0001_0000, 32'h0, 32'h0, 32'h0, 32'hffff_ffff};
        vtx_q.push_back(dv);
        vtx_q.push_back(rand_vtx(1'b0));
        // one clipped vertex, at each position; second case has a zero edge span
        queue_tri(3'b001);
        vtx_q.push_back(rand_vtx(1'b0));
        dv = '{32'h0002_0000, 32'h0003_0000, -32'sh0005_0000, -32'sh0001_0000,
               32'h0001_0000, 32'h0002_0000};
        vtx_q.push_back(dv);
        dv = '{32'h0004_0000, 32'h0001_0000, 32'h0002_0000, 32'h0006_0000,
               32'h0007_0000, -32'sh0001_0000};
        vtx_q.push_back(dv);
        queue_tri(3'b100);
        // two clipped, each kept position, then all clipped with minimal w
        queue_tri(3'b011);
        queue_tri(3'b101);
        queue_tri(3'b110);
        dv = '{32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
               32'h8000_0000, 32'h7fff_ffff};
        vtx_q.push_back(dv);
        vtx_q.push_back(rand_vtx(1'b1));
        vtx_q.push_back(rand_vtx(1'b1));
        wait_quiet();

        // Random phases: idle pattern by pair, viewport varied toward the extremes.
        for (int ph = 0; ph < 6; ph++) begin
            snd_idle = ph < 2 ? 23 : (ph < 4 ? 51 : 0);
            rcv_idle = ph < 2 ? 51 : (ph < 4 ? 23 : 0);
            case (ph)
                0: begin
                    cfg_write(CFG_SCALE_X, 32'h7fff_ffff);
                    cfg_write(CFG_OFFSET_X, 32'h7fff_ffff);
                    cfg_write(CFG_SCALE_Y, 32'h8000_0000);
                    cfg_write(CFG_OFFSET_Y, 32'h8000_0000);
                end
                1: begin
                    cfg_write(CFG_SCALE_X, 32'h0);
                    cfg_write(CFG_OFFSET_X, 32'h8000_0000);
                    cfg_write(CFG_SCALE_Y, 32'h7fff_ffff);
                    cfg_write(CFG_OFFSET_Y, 32'h7fff_ffff);
                end
                default: begin
                    cfg_write(CFG_SCALE_X, $urandom);
                    cfg_write(CFG_OFFSET_X, $urandom);
                    cfg_write(CFG_SCALE_Y, rand_word());
                    cfg_write(CFG_OFFSET_Y, rand_word());
                end
            endcase
            // out-of-range index must leave the viewport alone
            cfg_write(3'($urandom_range(CFG_FIRST_BAD, 7)), $urandom);
            for (int n = 0; n < 20; n++) begin
                if ($urandom_range(0, 9) == 0) begin
                    for (int i = 0; i < 3; i++) begin
                        dv = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
                        vtx_q.push_back(dv);
                    end
                end else begin
                    queue_tri(3'($urandom_range(0, 7)));
                end
            end
            wait_quiet();
        end

        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
`default_nettype wire
